// ----- sv/sfv_pkg.sv -----
package sfv_pkg;

	localparam int unsigned CountWidth = 16;
	localparam logic [CountWidth-1:0] MinFrameLen = 16'd17;
	localparam logic [7:0] SyncByte = 8'hAA;
	localparam logic [3:0] TypeLimit = 4'd6;
	localparam logic [CountWidth-1:0] TrailerLen = 16'd2;
	localparam logic [15:0] CrcPoly = 16'h1021;
	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [CountWidth-1:0] CountMax = 16'hFFFF;

	typedef enum logic [2:0] {
		REASON_OK = 3'd0,
		REASON_SHORT = 3'd1,
		REASON_SYNC = 3'd2,
		REASON_TYPE = 3'd3,
		REASON_SIZE = 3'd4,
		REASON_CRC = 3'd5
	} fail_reason_t;

endpackage

// ----- sv/sfv_in_if.sv -----
interface sfv_in_if;
	logic valid;
	logic ready;
	logic [7:0] payload_byte;
	logic last_byte;

	modport source(output valid, output payload_byte, output last_byte, input ready);
	modport sink(input valid, input payload_byte, input last_byte, output ready);
endinterface

// ----- sv/sfv_out_if.sv -----
interface sfv_out_if;
	logic valid;
	logic ready;
	logic is_match;
	logic [2:0] fail_reason;

	modport source(output valid, output is_match, output fail_reason, input ready);
	modport sink(input valid, input is_match, input fail_reason, output ready);
endinterface

// ----- sv/sfv_crc_step.sv -----
module sfv_crc_step
	import sfv_pkg::*;
(
	input  logic [15:0] crc,
	input  logic [7:0]  data,
	output logic [15:0] crc_next
);

	always_comb begin
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_next = c;
	end

endmodule

// ----- sv/synchrophasor_frame_validator_core.sv -----
// Synchrophasor frame validator.
// The byte_req channel carries one packet byte per request, with last_byte set
// on the final byte of a packet. The verdict channel carries one result per
// packet: is_match and a fail_reason code (ok, short, bad sync, bad type,
// size mismatch, CRC mismatch); the failures are checked in that order of priority.
// A byte may be accepted in every cycle in which byte_req.ready is high.
// An accepted byte sits in an input register while the packet
// state (count, captures, CRC-16/CCITT-FALSE register, two-byte delay) is
// updated; the verdict for a last byte is loaded into the result register when
// that byte leaves the input register.
// While a verdict waits in the result register, non-final bytes keep flowing;
// only a final byte in the input register waits until the result register
// is free or being taken, and byte_req.ready drops in the meantime.
// Reset clears both registers and returns the packet state to its start
// values, so the next byte is taken as byte 0 of a new packet.
module synchrophasor_frame_validator_core
	import sfv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	sfv_in_if.sink byte_req,
	sfv_out_if.source verdict
);

	logic valid_s1;
	logic last_s1;
	logic [7:0] byte_s1;
	logic adv_s1;

	logic [CountWidth-1:0] count_q;
	logic [15:0] crc_q;
	logic [15:0] held_q;
	logic [15:0] size_q;
	logic sync_ok_q;
	logic type_ok_q;
	logic over_q;

	logic out_valid_q;
	logic is_match_q;
	fail_reason_t reason_q;

	logic [15:0] crc_fed;
	logic [CountWidth-1:0] count_d;
	logic [15:0] crc_d;
	logic [15:0] held_d;
	logic [15:0] size_d;
	logic sync_ok_d;
	logic type_ok_d;
	logic over_d;
	fail_reason_t reason_d;

	assign adv_s1 = valid_s1 && (!last_s1 || !out_valid_q || verdict.ready);
	assign byte_req.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else if (byte_req.ready) begin
			valid_s1 <= byte_req.valid;
			last_s1 <= byte_req.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_req.ready && byte_req.valid) begin
			byte_s1 <= byte_req.payload_byte;
		end
	end

	sfv_crc_step u_crc_step (
		.crc(crc_q),
		.data(held_q[15:8]),
		.crc_next(crc_fed)
	);

	always_comb begin
		sync_ok_d = sync_ok_q;
		type_ok_d = type_ok_q;
		size_d = size_q;
		if (count_q == 16'd0) begin
			sync_ok_d = (byte_s1 == SyncByte);
		end else if (count_q == 16'd1) begin
			type_ok_d = (byte_s1[7:4] < TypeLimit);
		end else if (count_q == 16'd2) begin
			size_d = {byte_s1, size_q[7:0]};
		end else if (count_q == 16'd3) begin
			size_d = {size_q[15:8], byte_s1};
		end
		crc_d = (count_q >= TrailerLen) ? crc_fed : crc_q;
		held_d = {held_q[7:0], byte_s1};
		over_d = over_q || (count_q == CountMax);
		count_d = (count_q == CountMax) ? count_q : count_q + 16'd1;

		if (!over_d && count_d < MinFrameLen) begin
			reason_d = REASON_SHORT;
		end else if (!sync_ok_d) begin
			reason_d = REASON_SYNC;
		end else if (!type_ok_d) begin
			reason_d = REASON_TYPE;
		end else if (over_d || size_d != count_d) begin
			reason_d = REASON_SIZE;
		end else if (held_d != crc_d) begin
			reason_d = REASON_CRC;
		end else begin
			reason_d = REASON_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q <= CrcInit;
			held_q <= '0;
			size_q <= '0;
			sync_ok_q <= 1'b0;
			type_ok_q <= 1'b0;
			over_q <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				count_q <= '0;
				crc_q <= CrcInit;
				held_q <= '0;
				size_q <= '0;
				sync_ok_q <= 1'b0;
				type_ok_q <= 1'b0;
				over_q <= 1'b0;
			end else begin
				count_q <= count_d;
				crc_q <= crc_d;
				held_q <= held_d;
				size_q <= size_d;
				sync_ok_q <= sync_ok_d;
				type_ok_q <= type_ok_d;
				over_q <= over_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			is_match_q <= (reason_d == REASON_OK);
			reason_q <= reason_d;
		end
	end

	assign verdict.valid = out_valid_q;
	assign verdict.is_match = is_match_q;
	assign verdict.fail_reason = reason_q;

	a_over_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		over_q |-> count_q == CountMax)
		else $error("overflow flag set without a saturated byte count");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> count_q == '0 && crc_q == CrcInit && !over_q)
		else $error("packet state not cleared after a final byte");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv_s1 && last_s1))
		else $error("verdict appeared without a final byte");

	a_match_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> is_match_q == (reason_q == REASON_OK))
		else $error("is_match disagrees with fail_reason");

endmodule
